@@ rtl/core/ceb_pkg.sv @@
// shared constants and types for the cursor edit buffer
package ceb_pkg;

  // default capacity of the character store
  localparam int CEB_MAX_LEN = 256;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_ERASE  = 3'd1;
  localparam logic [2:0] OP_LEFT   = 3'd2;
  localparam logic [2:0] OP_RIGHT  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BOUNDARY = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // one finished result travelling from the sequencer to the output stage
  typedef struct packed {
    logic [7:0] read_char;
    logic [8:0] cursor_pos;
    logic [8:0] text_length;
    logic [1:0] status;
  } ceb_res_t;

endpackage

@@ rtl/core/ceb_store.sv @@
// character store: one write port and one registered read port
module ceb_store import ceb_pkg::*; #(
  parameter int MAX_LEN = CEB_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(MAX_LEN)-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(MAX_LEN)-1:0] rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem [MAX_LEN];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds its value between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/ceb_seq.sv @@
// sequencer: decodes operations, keeps cursor and length, moves entries one at a time
module ceb_seq import ceb_pkg::*; #(
  parameter int MAX_LEN = CEB_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [2:0]                 in_op,
  input  logic [7:0]                 in_ch,
  input  logic [7:0]                 in_read_index,
  output logic                       busy,
  output logic                       mem_wr_en,
  output logic [$clog2(MAX_LEN)-1:0] mem_wr_addr,
  output logic [7:0]                 mem_wr_data,
  output logic                       mem_rd_en,
  output logic [$clog2(MAX_LEN)-1:0] mem_rd_addr,
  input  logic [7:0]                 mem_rd_data,
  output logic                       res_valid,
  output ceb_res_t                   res,
  input  logic                       res_ready
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SH_RD   = 6'b000010,
    S_SH_WR   = 6'b000100,
    S_UPDATE  = 6'b001000,
    S_RD_WAIT = 6'b010000,
    S_FIN     = 6'b100000
  } seq_state_t;

  seq_state_t    state_r, state_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] length_r, length_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [7:0]    rdchar_r, rdchar_nxt;

  logic          ins;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic [31:0]   rd_idx_w;
  logic [31:0]   cursor_w;
  logic [31:0]   length_w;

  assign ins      = (op_r == OP_INSERT);
  assign idx_dec  = idx_r - CW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign rd_idx_w = 32'(in_read_index);
  assign cursor_w = 32'(cursor_r);
  assign length_w = 32'(length_r);

  // next state and memory control
  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    length_nxt  = length_r;
    idx_nxt     = idx_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    status_nxt  = status_r;
    rdchar_nxt  = rdchar_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cursor_r[AW-1:0];
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          ch_nxt     = in_ch;
          status_nxt = ST_DONE;
          rdchar_nxt = 8'd0;
          state_nxt  = S_FIN;
          unique case (in_op)
            OP_INSERT: begin
              if (length_r >= CW'(MAX_LEN)) begin
                status_nxt = ST_FULL;
              end else begin
                idx_nxt   = length_r;
                state_nxt = (length_r > cursor_r) ? S_SH_RD : S_UPDATE;
              end
            end
            OP_ERASE: begin
              if (cursor_r == '0) begin
                status_nxt = ST_BOUNDARY;
              end else begin
                idx_nxt   = cursor_r;
                state_nxt = (cursor_r < length_r) ? S_SH_RD : S_UPDATE;
              end
            end
            OP_LEFT: begin
              if (cursor_r == '0) begin
                status_nxt = ST_BOUNDARY;
              end else begin
                cursor_nxt = cursor_r - CW'(1);
              end
            end
            OP_RIGHT: begin
              if (cursor_r >= length_r) begin
                status_nxt = ST_BOUNDARY;
              end else begin
                cursor_nxt = cursor_r + CW'(1);
              end
            end
            OP_CLEAR: begin
              cursor_nxt = '0;
              length_nxt = '0;
            end
            OP_READ: begin
              if (rd_idx_w < length_w && rd_idx_w < MAX_LEN) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = rd_idx_w[AW-1:0];
                state_nxt   = S_RD_WAIT;
              end
            end
            default: begin
              status_nxt = ST_BOUNDARY;
            end
          endcase
        end
      end

      // fetch the entry to be moved
      S_SH_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = ins ? idx_dec[AW-1:0] : idx_r[AW-1:0];
        state_nxt   = S_SH_WR;
      end

      // store it one place up (insert) or one place down (erase)
      S_SH_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = mem_rd_data;
        if (ins) begin
          mem_wr_addr = idx_r[AW-1:0];
          idx_nxt     = idx_dec;
          state_nxt   = (idx_dec > cursor_r) ? S_SH_RD : S_UPDATE;
        end else begin
          mem_wr_addr = idx_dec[AW-1:0];
          idx_nxt     = idx_inc;
          state_nxt   = (idx_inc < length_r) ? S_SH_RD : S_UPDATE;
        end
      end

      // place the new character, or close the gap, and move the counts
      S_UPDATE: begin
        if (ins) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cursor_r[AW-1:0];
          mem_wr_data = ch_r;
          cursor_nxt  = cursor_r + CW'(1);
          length_nxt  = length_r + CW'(1);
        end else begin
          cursor_nxt  = cursor_r - CW'(1);
          length_nxt  = length_r - CW'(1);
        end
        state_nxt = S_FIN;
      end

      S_RD_WAIT: begin
        rdchar_nxt = mem_rd_data;
        state_nxt  = S_FIN;
      end

      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      length_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      length_r <= length_nxt;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    op_r     <= op_nxt;
    ch_r     <= ch_nxt;
    status_r <= status_nxt;
    rdchar_r <= rdchar_nxt;
  end

  // result, counts reported to nine bits
  assign busy            = (state_r != S_IDLE);
  assign res_valid       = (state_r == S_FIN);
  assign res.read_char   = rdchar_r;
  assign res.cursor_pos  = cursor_w[8:0];
  assign res.text_length = length_w[8:0];
  assign res.status      = status_r;

endmodule

@@ rtl/core/ceb_out_stage.sv @@
// output register holding one result transaction for the receiving side
module ceb_out_stage import ceb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  input  ceb_res_t   res,
  output logic       res_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_char,
  output logic [8:0] out_cursor_pos,
  output logic [8:0] out_text_length,
  output logic [1:0] out_status
);

  logic     out_valid_r;
  ceb_res_t hold_r;

  assign res_ready = !out_valid_r || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      hold_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_char   = hold_r.read_char;
  assign out_cursor_pos  = hold_r.cursor_pos;
  assign out_text_length = hold_r.text_length;
  assign out_status      = hold_r.status;

endmodule

@@ rtl/core/cursor_edit_buffer_core.sv @@
// top level of the cursor edit buffer
//
//   channel  ports                                   direction  transaction
//   in       in_valid in_stall in_op in_ch           into core  one edit operation
//            in_read_index
//   out      out_valid out_stall out_read_char       out        one result per operation
//            out_cursor_pos out_text_length out_status
//
// one operation at a time; in_stall is high from acceptance until the result
// has moved into the output register.
// insert and erase move entries one at a time, each moved entry costing a read
// and a write on the character store, never both at once; a read inside the text
// waits on the registered read port, every other operation (refused and ignored
// ones included) goes straight to the final state. the output register holds one
// result, so out_stall keeps the sequencer in its final state only when it is full.
// reset clears state, cursor and length only; the store needs no clearing pass.
module cursor_edit_buffer_core import ceb_pkg::*; #(
  parameter int MAX_LEN = CEB_MAX_LEN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_ch,
  input  logic [7:0] in_read_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_char,
  output logic [8:0] out_cursor_pos,
  output logic [8:0] out_text_length,
  output logic [1:0] out_status
);

  localparam int AW = $clog2(MAX_LEN);

  logic          busy;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;
  logic          res_valid;
  logic          res_ready;
  ceb_res_t      res;

  assign in_stall = busy;

  // operation sequencer
  ceb_seq #(.MAX_LEN(MAX_LEN)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_op         (in_op),
    .in_ch         (in_ch),
    .in_read_index (in_read_index),
    .busy          (busy),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  // character store
  ceb_store #(.MAX_LEN(MAX_LEN)) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register
  ceb_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_char   (out_read_char),
    .out_cursor_pos  (out_cursor_pos),
    .out_text_length (out_text_length),
    .out_status      (out_status)
  );

  // an accepted transaction always occupies the sequencer in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer free right after accepting a transaction");

  // a finished result keeps the input side closed
  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_stall)
    else $error("input open while a result is pending");

  // a pending result waits unchanged until the output register takes it
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result lost or changed");

  // the character store is never read and written in the same cycle
  a_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("store read and written together");

endmodule
